[rtl/core/spq_pkg.sv]
// sorted priority queue package: item, result and cell types, depth default
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

	localparam int unsigned QueueDepthDef = 16;
	localparam int unsigned CountOutW     = 5;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] data_value;
		logic [15:0]        priority_value;
	} in_item_t;

	typedef struct packed {
		logic                 pop_valid;
		logic signed [31:0]   popped_data;
		logic [15:0]          popped_priority;
		logic                 overflow;
		logic [CountOutW-1:0] entry_count;
		logic                 queue_empty;
	} result_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic [15:0]        pri;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

[rtl/core/sorted_priority_queue_top.sv]
// sorted priority queue top: row of spq_cell slots, highest priority at slot 0
// depends on spq_pkg, spq_cell
// the result strobe is registered and rises in the cycle after the item is accepted
// throughput: one item per cycle, busy stays low; every cell compares and shifts at once
// reset clears the entry count and the result strobe; slot contents are left as they are
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
	parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  spq_pkg::in_item_t item,
	output logic              done,
	output spq_pkg::result_t  result
);

	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	logic [CntW-1:0]    count_q;
	logic [CntW-1:0]    count_next;
	logic               accept;
	logic               is_pop;
	logic               full;
	logic               empty;
	spq_pkg::cell_ctl_t ctl;
	spq_pkg::entry_t    new_ent;
	spq_pkg::entry_t    ent_w  [QUEUE_DEPTH];
	logic               keep_w [QUEUE_DEPTH];
	spq_pkg::result_t   res_d;
	spq_pkg::result_t   result_q;
	logic               done_q;
	logic [31:0]        count_ext;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign is_pop  = (item.action == spq_pkg::ACT_POP);
	assign full    = (count_q == CntW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign ctl.push = accept && !is_pop && !full;
	assign ctl.pop  = accept && is_pop && !empty;
	assign new_ent.data = item.data_value;
	assign new_ent.pri  = item.priority_value;

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			logic            occ;
			logic            lk;
			spq_pkg::entry_t le;
			spq_pkg::entry_t re;

			assign occ = (CntW'(i) < count_q);
			if (i == 0) begin : g_first
				assign lk = 1'b1;
				assign le = new_ent;
			end else begin : g_mid
				assign lk = keep_w[i-1];
				assign le = ent_w[i-1];
			end
			if (i == QUEUE_DEPTH - 1) begin : g_last
				assign re = ent_w[i];
			end else begin : g_body
				assign re = ent_w[i+1];
			end

			spq_cell u_cell (
				.clk       (clk),
				.occ       (occ),
				.left_keep (lk),
				.left_ent  (le),
				.right_ent (re),
				.new_ent   (new_ent),
				.ctl       (ctl),
				.ent       (ent_w[i]),
				.keep      (keep_w[i])
			);
		end
	endgenerate

	always_comb begin
		count_next = count_q;
		if (ctl.push) begin
			count_next = count_q + 1'b1;
		end else if (ctl.pop) begin
			count_next = count_q - 1'b1;
		end
	end

	assign count_ext = 32'(count_next);

	always_comb begin
		res_d                 = '0;
		res_d.pop_valid       = ctl.pop;
		res_d.popped_data     = ctl.pop ? ent_w[0].data : '0;
		res_d.popped_priority = ctl.pop ? ent_w[0].pri : '0;
		res_d.overflow        = accept && !is_pop && full;
		res_d.entry_count     = count_ext[spq_pkg::CountOutW-1:0];
		res_d.queue_empty     = (count_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/core/spq_cell.sv]
// one slot of the sorted chain: holds an entry; on a push it inserts or shifts down, on a pop it shifts up
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell (
	input  logic              clk,
	input  logic              occ,
	input  logic              left_keep,
	input  spq_pkg::entry_t   left_ent,
	input  spq_pkg::entry_t   right_ent,
	input  spq_pkg::entry_t   new_ent,
	input  spq_pkg::cell_ctl_t ctl,
	output spq_pkg::entry_t   ent,
	output logic              keep
);

	spq_pkg::entry_t ent_q;

	assign keep = occ && (ent_q.pri >= new_ent.pri);
	assign ent  = ent_q;

	always_ff @(posedge clk) begin
		if (ctl.push && !keep) begin
			ent_q <= left_keep ? new_ent : left_ent;
		end else if (ctl.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

[rtl/core/spq_chk.sv]
// port-level checker for the sorted priority queue, bound to the top level
// depends on spq_pkg, sorted_priority_queue_top
`timescale 1ns / 1ps

module spq_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input spq_pkg::in_item_t item,
	input logic              done,
	input spq_pkg::result_t  result
);

	// every accepted item gives its result on the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted item gave no result");

	a_pop_xor_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.pop_valid && result.overflow))
		else $error("pop and overflow in one result");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.pop_valid) |->
		(result.popped_data == '0 && result.popped_priority == '0))
		else $error("popped fields nonzero without a pop");

	a_ovf_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.overflow) |-> !result.queue_empty)
		else $error("overflow on an empty queue");

	// back to back pops come out in non-increasing priority
	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && result.pop_valid && $past(result.pop_valid)) |->
		(result.popped_priority <= $past(result.popped_priority)))
		else $error("pops out of priority order");

endmodule

bind sorted_priority_queue_top spq_chk u_spq_chk (.*);

[verif/tb.sv]
// testbench for sorted_priority_queue_top: directed and random push/pop items, checked
// against an in-bench sorted store model, with bursty start and random gaps
// depends on spq_pkg and sorted_priority_queue_top
`timescale 1ns / 1ps

module tb;
	import spq_pkg::*;

	localparam int unsigned Depth = QueueDepthDef;
	localparam int unsigned RandomItems = 1250;
	localparam int unsigned MaxPrinted = 60;

	logic     clk;
	logic     arst_n;
	logic     start = 1'b0;
	logic     busy;
	in_item_t item = '0;
	logic     done;
	result_t  result;

	sorted_priority_queue_top #(
		.QUEUE_DEPTH(Depth)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	in_item_t    pending_items[$];
	result_t     awaited_results[$];
	int unsigned err_count = 0;
	bit          took = 1'b0;
	int unsigned burst_left = 8;
	int unsigned gap_left = 0;

	logic signed [31:0] store_data[Depth];
	logic [15:0]        store_pri[Depth];
	int unsigned        store_fill = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one step of the sorted store: lowest priority at slot 0, top slot pops
	function automatic result_t sorted_store_step(in_item_t it);
		result_t     r;
		int unsigned pos;
		r = '0;
		if (it.action == ACT_PUSH) begin
			if (store_fill >= Depth) begin
				r.overflow = 1'b1;
			end else begin
				pos = 0;
				while (pos < store_fill && store_pri[pos] < it.priority_value)
					pos++;
				for (int unsigned k = store_fill; k > pos; k--) begin
					store_data[k] = store_data[k - 1];
					store_pri[k]  = store_pri[k - 1];
				end
				store_data[pos] = it.data_value;
				store_pri[pos]  = it.priority_value;
				store_fill++;
			end
		end else if (store_fill > 0) begin
			store_fill--;
			r.pop_valid       = 1'b1;
			r.popped_data     = store_data[store_fill];
			r.popped_priority = store_pri[store_fill];
		end
		r.entry_count = store_fill[CountOutW-1:0];
		r.queue_empty = (store_fill == 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (err_count < MaxPrinted)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		err_count++;
	endtask

	function automatic in_item_t make_item(action_t act, logic [31:0] dat, logic [15:0] pri);
		in_item_t it;
		it.action         = act;
		it.data_value     = dat;
		it.priority_value = pri;
		return it;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && took) begin
				void'(pending_items.pop_front());
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
			if (!(start && !took)) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (pending_items.size() != 0) begin
					start <= 1'b1;
					item  <= pending_items[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		took = arst_n && start && !busy;
		if (done === 1'b1) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with no item waiting", '0, '0);
			end else begin
				want = awaited_results.pop_front();
				if (result.pop_valid !== want.pop_valid)
					report_mismatch("pop_valid", 32'(result.pop_valid),
						32'(want.pop_valid));
				if (result.popped_data !== want.popped_data)
					report_mismatch("popped_data", result.popped_data, want.popped_data);
				if (result.popped_priority !== want.popped_priority)
					report_mismatch("popped_priority", 32'(result.popped_priority),
						32'(want.popped_priority));
				if (result.overflow !== want.overflow)
					report_mismatch("overflow", 32'(result.overflow), 32'(want.overflow));
				if (result.entry_count !== want.entry_count)
					report_mismatch("entry_count", 32'(result.entry_count),
						32'(want.entry_count));
				if (result.queue_empty !== want.queue_empty)
					report_mismatch("queue_empty", 32'(result.queue_empty),
						32'(want.queue_empty));
			end
		end
		if (took)
			awaited_results.push_back(sorted_store_step(item));
	end

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int unsigned push_pct;
		int unsigned pri_mode;
		logic [15:0] pri;
		in_item_t    it;

		arst_n = 1'b0;

		// empty pops, extremes, ties, fill to full, overflow, drain a few
		pending_items.push_back(make_item(ACT_POP, 32'h7fff_ffff, 16'hffff));
		pending_items.push_back(make_item(ACT_POP, 32'h8000_0000, 16'h0000));
		pending_items.push_back(make_item(ACT_PUSH, 32'h8000_0000, 16'h0000));
		pending_items.push_back(make_item(ACT_PUSH, 32'h7fff_ffff, 16'hffff));
		pending_items.push_back(make_item(ACT_PUSH, 32'h0000_0000, 16'h0000));
		pending_items.push_back(make_item(ACT_PUSH, 32'hffff_ffff, 16'hffff));
		pending_items.push_back(make_item(ACT_PUSH, 32'd1, 16'd100));
		pending_items.push_back(make_item(ACT_PUSH, 32'd2, 16'd100));
		pending_items.push_back(make_item(ACT_PUSH, 32'd3, 16'd100));
		pending_items.push_back(make_item(ACT_PUSH, 32'h5555_5555, 16'h5555));
		pending_items.push_back(make_item(ACT_PUSH, 32'haaaa_aaaa, 16'haaaa));
		pending_items.push_back(make_item(ACT_PUSH, 32'd5, 16'd1));
		pending_items.push_back(make_item(ACT_PUSH, 32'd6, 16'hfffe));
		pending_items.push_back(make_item(ACT_PUSH, 32'd7, 16'h8000));
		pending_items.push_back(make_item(ACT_PUSH, 32'd8, 16'h7fff));
		pending_items.push_back(make_item(ACT_PUSH, 32'd9, 16'd100));
		pending_items.push_back(make_item(ACT_PUSH, 32'd10, 16'h0000));
		pending_items.push_back(make_item(ACT_PUSH, 32'd11, 16'hffff));
		pending_items.push_back(make_item(ACT_PUSH, 32'd12, 16'd200));
		repeat (4) pending_items.push_back(make_item(ACT_POP, 32'hdead_beef, 16'h1234));

		push_pct = 50;
		pri_mode = 1;
		for (int unsigned n = 0; n < RandomItems; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
				pri_mode = $urandom_range(0, 2);
			end
			case (pri_mode)
				0: pri = 16'($urandom_range(0, 3));
				1: pri = 16'($urandom_range(0, 65535));
				default: begin
					case ($urandom_range(0, 3))
						0: pri = 16'h0000;
						1: pri = 16'h0001;
						2: pri = 16'hfffe;
						default: pri = 16'hffff;
					endcase
				end
			endcase
			it = make_item(($urandom_range(1, 100) <= push_pct) ? ACT_PUSH : ACT_POP,
				$urandom, pri);
			pending_items.push_back(it);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[sorted_priority_queue_top.f]
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_top.sv
rtl/core/spq_chk.sv
verif/tb.sv
